// File: hdl/gpb_pkg.sv
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared types and constants of the GPIO port bank: register offsets,
// per-port register set, request and result records.
// ----------------------------------------------------------------------------
package gpb_pkg;

  localparam int NUM_PORTS    = 4;
  localparam int WINDOW_BYTES = 4096;

  localparam int PINS_W      = 8;
  localparam int OFFSET_W    = 12;
  localparam int WORD_W      = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;
  localparam int IN_TUSER_W  = 2;

  // Byte offsets inside one port window
  localparam logic [OFFSET_W-1:0] DATA_WINDOW_END = 12'h400;
  localparam logic [OFFSET_W-1:0] OFF_DIR   = 12'h400;
  localparam logic [OFFSET_W-1:0] OFF_IS    = 12'h404;
  localparam logic [OFFSET_W-1:0] OFF_IBE   = 12'h408;
  localparam logic [OFFSET_W-1:0] OFF_IEV   = 12'h40C;
  localparam logic [OFFSET_W-1:0] OFF_IE    = 12'h410;
  localparam logic [OFFSET_W-1:0] OFF_RIS   = 12'h414;
  localparam logic [OFFSET_W-1:0] OFF_MIS   = 12'h418;
  localparam logic [OFFSET_W-1:0] OFF_ICR   = 12'h41C;
  localparam logic [OFFSET_W-1:0] OFF_AFSEL = 12'h420;
  localparam logic [OFFSET_W-1:0] OFF_LOCK  = 12'h520;
  localparam logic [OFFSET_W-1:0] OFF_CR    = 12'h524;
  localparam logic [OFFSET_W-1:0] OFF_PMUX  = 12'h700;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DRIVE = 2'd2,
    OP_EDGE  = 2'd3
  } gpb_op_t;

  typedef struct packed {
    logic [PINS_W-1:0] pin_data;
    logic [PINS_W-1:0] pin_direction;
    logic [PINS_W-1:0] int_sense;
    logic [PINS_W-1:0] int_both_edges;
    logic [PINS_W-1:0] int_event;
    logic [PINS_W-1:0] int_enable;
    logic [PINS_W-1:0] raw_status;
    logic [PINS_W-1:0] alt_function;
    logic [PINS_W-1:0] commit_mask;
    logic [WORD_W-1:0] lock_word;
    logic [WORD_W-1:0] pin_mux;
  } port_regs_t;

  typedef struct packed {
    gpb_op_t             operation;
    logic [1:0]          port_sel;
    logic [OFFSET_W-1:0] reg_offset;
    logic [WORD_W-1:0]   write_data;
    logic [2:0]          pin_index;
    logic                pin_level;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              data_changed;
    logic [PINS_W-1:0] old_pins;
    logic [PINS_W-1:0] new_pins;
    logic              irq_request;
    logic [1:0]        irq_line;
  } result_t;

endpackage

// File: hdl/gpb_port_update.sv
// ----------------------------------------------------------------------------
// gpb_port_update
// Single-pass request logic for one port: register read mux, register write
// decode, pin drive and forced interrupt edge.
// ----------------------------------------------------------------------------
module gpb_port_update (
  input  gpb_pkg::item_t     item,
  input  gpb_pkg::port_regs_t cur,
  output gpb_pkg::port_regs_t nxt,
  output gpb_pkg::result_t    res
);
  import gpb_pkg::*;

  logic [PINS_W-1:0] pin_mask;
  logic [PINS_W-1:0] data_mask;
  logic [PINS_W-1:0] wr_byte;
  logic [PINS_W-1:0] masked_data;
  logic              in_window;
  logic              in_data;

  assign pin_mask    = PINS_W'(1) << item.pin_index;
  assign data_mask   = item.reg_offset[9:2];
  assign wr_byte     = item.write_data[PINS_W-1:0];
  assign masked_data = (cur.pin_data & ~data_mask) | (wr_byte & data_mask);
  assign in_window   = {1'b0, item.reg_offset} < (OFFSET_W+1)'(WINDOW_BYTES);
  assign in_data     = item.reg_offset < DATA_WINDOW_END;

  always_comb begin
    nxt = cur;
    res = '0;
    case (item.operation)
      OP_READ: begin
        if (in_window) begin
          if (in_data) begin
            res.read_data = WORD_W'(cur.pin_data & data_mask);
          end else begin
            case (item.reg_offset)
              OFF_DIR:   res.read_data = WORD_W'(cur.pin_direction);
              OFF_IS:    res.read_data = WORD_W'(cur.int_sense);
              OFF_IBE:   res.read_data = WORD_W'(cur.int_both_edges);
              OFF_IEV:   res.read_data = WORD_W'(cur.int_event);
              OFF_IE:    res.read_data = WORD_W'(cur.int_enable);
              OFF_RIS:   res.read_data = WORD_W'(cur.raw_status);
              OFF_MIS:   res.read_data = WORD_W'(cur.raw_status & cur.int_enable);
              OFF_AFSEL: res.read_data = WORD_W'(cur.alt_function);
              OFF_LOCK:  res.read_data = cur.lock_word;
              OFF_CR:    res.read_data = WORD_W'(cur.commit_mask);
              OFF_PMUX:  res.read_data = cur.pin_mux;
              default:   res.read_data = '0;
            endcase
          end
        end
      end
      OP_WRITE: begin
        if (in_window) begin
          if (in_data) begin
            nxt.pin_data     = masked_data;
            res.data_changed = masked_data != cur.pin_data;
            res.old_pins     = cur.pin_data;
            res.new_pins     = masked_data;
          end else begin
            case (item.reg_offset)
              OFF_DIR:   nxt.pin_direction  = wr_byte;
              OFF_IS:    nxt.int_sense      = wr_byte;
              OFF_IBE:   nxt.int_both_edges = wr_byte;
              OFF_IEV:   nxt.int_event      = wr_byte;
              OFF_IE:    nxt.int_enable     = wr_byte;
              OFF_ICR:   nxt.raw_status     = cur.raw_status & ~wr_byte;
              OFF_AFSEL: nxt.alt_function   = wr_byte;
              OFF_LOCK:  nxt.lock_word      = item.write_data;
              OFF_CR:    nxt.commit_mask    = wr_byte;
              OFF_PMUX:  nxt.pin_mux        = item.write_data;
              default:   nxt = cur;
            endcase
          end
        end
      end
      OP_DRIVE: begin
        // output pins ignore external drive
        if ((cur.pin_direction & pin_mask) == '0) begin
          nxt.pin_data = item.pin_level ? (cur.pin_data | pin_mask)
                                        : (cur.pin_data & ~pin_mask);
        end
      end
      default: begin
        nxt.int_enable  = cur.int_enable | pin_mask;
        nxt.raw_status  = item.pin_level ? (cur.raw_status | pin_mask)
                                         : (cur.raw_status & ~pin_mask);
        res.irq_request = |(nxt.raw_status & nxt.int_enable);
        res.irq_line    = item.port_sel;
      end
    endcase
  end

endmodule

// File: hdl/gpio_port_bank_registers.sv
// ----------------------------------------------------------------------------
// gpio_port_bank_registers
// Four 8-pin GPIO ports behind per-port register windows, with masked data
// access, pin drive and forced interrupt edges. One result per request.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in_     | sink      | in_tvalid / in_tready   | in_tuser operation, in_tdata
//  out_    | source    | out_tvalid / out_tready | out_tdata result fields
//
//  A request enters an input register, then one pass of logic reads and updates
//  the addressed port and loads the result register. Throughput is one request
//  per cycle while the result register is not stalled; out_tvalid rises when the
//  request moves from the input register into the result register, and the
//  port update between those two registers is combinational.
//  rst_n (synchronous, active low) clears both valid flags and all port state.
//  A stalled result holds its register; the input stage still takes a new
//  request when the result register drains in the same cycle.
//
module gpio_port_bank_registers (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] operation
  input  logic [gpb_pkg::IN_TUSER_W-1:0]   in_tuser,
  // [1:0] port_sel, [13:2] reg_offset, [45:14] write_data,
  // [48:46] pin_index, [49] pin_level, [55:50] zero
  input  logic [gpb_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] read_data, [32] data_changed, [40:33] old_pins, [48:41] new_pins,
  // [49] irq_request, [51:50] irq_line, [55:52] zero
  output logic [gpb_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import gpb_pkg::*;

  // input register
  logic       s1_valid_r;
  item_t      s1_item_r;
  item_t      s1_item_nxt;

  // result register
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    out_res_nxt;

  // per-port register sets
  port_regs_t regs_r [NUM_PORTS];

  port_regs_t port_cur;
  port_regs_t port_nxt;
  result_t    port_res;
  logic       port_ok;
  logic       advance;

  // Unpack the request fields from the stream payload
  always_comb begin
    s1_item_nxt.operation  = gpb_op_t'(in_tuser[1:0]);
    s1_item_nxt.port_sel   = in_tdata[1:0];
    s1_item_nxt.reg_offset = in_tdata[13:2];
    s1_item_nxt.write_data = in_tdata[45:14];
    s1_item_nxt.pin_index  = in_tdata[48:46];
    s1_item_nxt.pin_level  = in_tdata[49];
  end

  // Move the held request forward whenever the result register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Select the addressed port; ports past the bank return an all-zero result
  assign port_ok  = {1'b0, s1_item_r.port_sel} < 3'(NUM_PORTS);
  assign port_cur = regs_r[s1_item_r.port_sel];

  gpb_port_update u_port_update (
    .item (s1_item_r),
    .cur  (port_cur),
    .nxt  (port_nxt),
    .res  (port_res)
  );

  assign out_res_nxt = port_ok ? port_res : '0;

  // Control state and port registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // commit the port update as the request leaves the input register
      if (advance && port_ok) begin
        regs_r[s1_item_r.port_sel] <= port_nxt;
      end
    end
  end

  // Payload registers: load on handshake, hold otherwise
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= s1_item_nxt;
    end
    if (advance) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       out_res_r.irq_line,
                       out_res_r.irq_request,
                       out_res_r.new_pins,
                       out_res_r.old_pins,
                       out_res_r.data_changed,
                       out_res_r.read_data};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An interrupt result never carries read data or a data change
  a_irq_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.irq_request |->
      out_res_r.read_data == '0 && !out_res_r.data_changed)
    else $error("irq result carries read or write data");

  // The change flag agrees with the reported old and new pins
  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.data_changed == (out_res_r.old_pins != out_res_r.new_pins))
    else $error("data_changed disagrees with old/new pins");

  // A held request stays put until it can advance
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost or changed a stalled request");

  // Every advanced request shows up as a result
  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced request produced no result");

endmodule

// File: tb/gpio_port_bank_registers_tb.sv
// ----------------------------------------------------------------------------
// gpio_port_bank_registers_tb
// Self-checking bench for the GPIO port bank: a short directed list walks
// every register, the masked data window and the pin drive and interrupt edge
// requests, then a long random mix runs under changing back-pressure. An
// in-bench copy of the four port register sets predicts every result.
// ----------------------------------------------------------------------------
module gpio_port_bank_registers_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpb_pkg::*;

  // Random part size and the points where the traffic pattern changes.
  localparam int RANDOM_REQUESTS = 1150;
  localparam int PHASE1_START    = 420;   // sender and receiver swap idle shares
  localparam int PHASE2_START    = 820;   // no idling from here on
  localparam int DRAIN_AT        = 600;   // sender waits for every result here
  localparam int HOLD_AT         = 950;   // receiver stops for a long stretch here
  localparam int HOLD_CYCLES     = 80;
  localparam int SETTLE_CYCLES   = 8;

  // Offsets that decode to no register.
  localparam logic [OFFSET_W-1:0] UNMAPPED_OFF = 12'h424;
  localparam logic [OFFSET_W-1:0] WINDOW_TOP   = 12'hFFF;
  localparam logic [OFFSET_W-1:0] MISALIGNED   = 12'h401;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow of the four port register sets and the results still owed.
  port_regs_t port_state [NUM_PORTS] = '{default: '0};
  result_t    pending_results [$];
  item_t      request_queue [$];

  int sent_total  = 0;   // requests accepted, counted by the driver
  int taken       = 0;   // requests accepted, counted by the monitor
  int results     = 0;
  int errors      = 0;
  int outstanding = 0;   // size of pending_results as of the last edge
  int op_count [4] = '{0, 0, 0, 0};
  logic draining  = 1'b0;
  int hold_left   = 0;
  logic hold_done = 1'b0;

  gpio_port_bank_registers dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one request to the shadow ports and return its result.
  // --------------------------------------------------------------------------
  function automatic result_t gpio_bank_update(item_t rq);
    result_t           r;
    logic [PINS_W-1:0] pin_bit;
    logic [PINS_W-1:0] wbyte;
    logic [PINS_W-1:0] mask;
    logic [PINS_W-1:0] prior;
    int                p;
    r = '0;
    p = int'(rq.port_sel);
    if (p >= NUM_PORTS) return r;
    pin_bit = 8'd1 << rq.pin_index;
    wbyte   = rq.write_data[7:0];
    mask    = rq.reg_offset[9:2];
    case (rq.operation)
      OP_READ: begin
        if (int'(rq.reg_offset) < WINDOW_BYTES) begin
          if (rq.reg_offset < DATA_WINDOW_END) begin
            r.read_data = {24'd0, port_state[p].pin_data & mask};
          end else begin
            case (rq.reg_offset)
              OFF_DIR:   r.read_data = {24'd0, port_state[p].pin_direction};
              OFF_IS:    r.read_data = {24'd0, port_state[p].int_sense};
              OFF_IBE:   r.read_data = {24'd0, port_state[p].int_both_edges};
              OFF_IEV:   r.read_data = {24'd0, port_state[p].int_event};
              OFF_IE:    r.read_data = {24'd0, port_state[p].int_enable};
              OFF_RIS:   r.read_data = {24'd0, port_state[p].raw_status};
              OFF_MIS:   r.read_data = {24'd0,
                                        port_state[p].raw_status & port_state[p].int_enable};
              OFF_AFSEL: r.read_data = {24'd0, port_state[p].alt_function};
              OFF_LOCK:  r.read_data = port_state[p].lock_word;
              OFF_CR:    r.read_data = {24'd0, port_state[p].commit_mask};
              OFF_PMUX:  r.read_data = port_state[p].pin_mux;
              default:   r.read_data = '0;
            endcase
          end
        end
      end
      OP_WRITE: begin
        if (int'(rq.reg_offset) < WINDOW_BYTES) begin
          if (rq.reg_offset < DATA_WINDOW_END) begin
            // Only the bits selected by the address change; report both sides.
            prior = port_state[p].pin_data;
            port_state[p].pin_data = (prior & ~mask) | (wbyte & mask);
            r.data_changed = (prior != port_state[p].pin_data);
            r.old_pins     = prior;
            r.new_pins     = port_state[p].pin_data;
          end else begin
            case (rq.reg_offset)
              OFF_DIR:   port_state[p].pin_direction  = wbyte;
              OFF_IS:    port_state[p].int_sense      = wbyte;
              OFF_IBE:   port_state[p].int_both_edges = wbyte;
              OFF_IEV:   port_state[p].int_event      = wbyte;
              OFF_IE:    port_state[p].int_enable     = wbyte;
              OFF_ICR:   port_state[p].raw_status     = port_state[p].raw_status & ~wbyte;
              OFF_AFSEL: port_state[p].alt_function   = wbyte;
              OFF_LOCK:  port_state[p].lock_word      = rq.write_data;
              OFF_CR:    port_state[p].commit_mask    = wbyte;
              OFF_PMUX:  port_state[p].pin_mux        = rq.write_data;
              default: ;  // status registers and holes ignore writes
            endcase
          end
        end
      end
      OP_DRIVE: begin
        // An output pin keeps its value.
        if ((port_state[p].pin_direction & pin_bit) == '0) begin
          if (rq.pin_level) port_state[p].pin_data = port_state[p].pin_data | pin_bit;
          else              port_state[p].pin_data = port_state[p].pin_data & ~pin_bit;
        end
      end
      default: begin
        port_state[p].int_enable = port_state[p].int_enable | pin_bit;
        if (rq.pin_level) port_state[p].raw_status = port_state[p].raw_status | pin_bit;
        else              port_state[p].raw_status = port_state[p].raw_status & ~pin_bit;
        r.irq_request = |(port_state[p].raw_status & port_state[p].int_enable);
        r.irq_line    = rq.port_sel;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t mk(gpb_op_t op, logic [1:0] port, logic [OFFSET_W-1:0] off,
                               logic [WORD_W-1:0] wd, logic [2:0] pin, logic lvl);
    item_t rq;
    rq.operation  = op;
    rq.port_sel   = port;
    rq.reg_offset = off;
    rq.write_data = wd;
    rq.pin_index  = pin;
    rq.pin_level  = lvl;
    return rq;
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_register();
    case ($urandom_range(11))
      0:       return OFF_DIR;
      1:       return OFF_IS;
      2:       return OFF_IBE;
      3:       return OFF_IEV;
      4:       return OFF_IE;
      5:       return OFF_RIS;
      6:       return OFF_MIS;
      7:       return OFF_ICR;
      8:       return OFF_AFSEL;
      9:       return OFF_LOCK;
      10:      return OFF_CR;
      default: return OFF_PMUX;
    endcase
  endfunction

  // Mostly data window and mapped registers, with some raw offsets as noise.
  function automatic item_t random_request();
    item_t rq;
    int    k;
    k = $urandom_range(99);
    rq.operation  = (k < 35) ? OP_READ : (k < 70) ? OP_WRITE : (k < 85) ? OP_DRIVE : OP_EDGE;
    rq.port_sel   = 2'($urandom_range(3));
    rq.write_data = $urandom();
    rq.pin_index  = 3'($urandom_range(7));
    rq.pin_level  = 1'($urandom_range(1));
    k = $urandom_range(99);
    if (k < 40)      rq.reg_offset = 12'($urandom_range(1023));
    else if (k < 85) rq.reg_offset = pick_register();
    else             rq.reg_offset = 12'($urandom_range(4095));
    return rq;
  endfunction

  // Idle share in percent for the current phase of the run.
  function automatic int idle_share(int count, bit for_sender);
    if (count < PHASE1_START) return for_sender ? 26 : 52;
    if (count < PHASE2_START) return for_sender ? 52 : 26;
    return 0;
  endfunction

  task automatic field_check(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer requests from the queue, hold each until accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic  accepted;
    item_t rq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      accepted = in_tvalid && in_tready;
      if (accepted) begin
        sent_total++;
        if (sent_total == DRAIN_AT) draining = 1'b1;
      end else if (draining && outstanding == 0) begin
        // outstanding is registered and lags the queue, but nothing new enters while draining
        draining = 1'b0;
      end
      if (!in_tvalid || accepted) begin
        if (draining || request_queue.size() == 0 ||
            $urandom_range(99) < idle_share(sent_total, 1'b1)) begin
          in_tvalid <= 1'b0;
        end else begin
          rq = request_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= rq.operation;
          in_tdata  <= {6'd0, rq.pin_level, rq.pin_index, rq.write_data,
                        rq.reg_offset, rq.port_sel};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted result,
  // and drive out_tready. Prediction and checking share one process so the
  // order of the two within an edge is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    item_t   seen;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.operation  = gpb_op_t'(in_tuser);
        seen.port_sel   = in_tdata[1:0];
        seen.reg_offset = in_tdata[13:2];
        seen.write_data = in_tdata[45:14];
        seen.pin_index  = in_tdata[48:46];
        seen.pin_level  = in_tdata[49];
        pending_results.push_back(gpio_bank_update(seen));
        op_count[int'(seen.operation)]++;
        taken++;
      end
      if (out_tvalid && out_tready) begin
        got.read_data    = out_tdata[31:0];
        got.data_changed = out_tdata[32];
        got.old_pins     = out_tdata[40:33];
        got.new_pins     = out_tdata[48:41];
        got.irq_request  = out_tdata[49];
        got.irq_line     = out_tdata[51:50];
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          field_check("read_data",    want.read_data,           got.read_data);
          field_check("data_changed", {31'd0, want.data_changed}, {31'd0, got.data_changed});
          field_check("old_pins",     {24'd0, want.old_pins},   {24'd0, got.old_pins});
          field_check("new_pins",     {24'd0, want.new_pins},   {24'd0, got.new_pins});
          field_check("irq_request",  {31'd0, want.irq_request}, {31'd0, got.irq_request});
          field_check("irq_line",     {30'd0, want.irq_line},   {30'd0, got.irq_line});
        end
        results++;
      end
      outstanding <= pending_results.size();
      // One long stall while the sender keeps offering: fill the pipe and
      // push back on the input side.
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_share(taken, 1'b0));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed requests, random mix, reset, then wait for the drain.
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    int total;
    // Masked data window: full mask, repeat write without change, partial
    // mask, zero mask and misaligned low address bits.
    request_queue.push_back(mk(OP_READ,  2'd0, 12'h3FC, 32'h0,         3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd0, 12'h3FC, 32'hFFFF_FFFF, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd0, 12'h3FC, 32'hFFFF_FFFF, 3'd7, 1'b1));
    request_queue.push_back(mk(OP_WRITE, 2'd1, 12'h03C, 32'h0000_00A5, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_READ,  2'd1, 12'h000, 32'h0,         3'd0, 1'b0));
    request_queue.push_back(mk(OP_READ,  2'd1, 12'h3FF, 32'h0,         3'd0, 1'b0));
    // Drive an input pin high, then an output pin (held) both ways.
    request_queue.push_back(mk(OP_WRITE, 2'd2, OFF_DIR, 32'hFFFF_FF0F, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_DRIVE, 2'd2, 12'h000, 32'h0,         3'd7, 1'b1));
    request_queue.push_back(mk(OP_DRIVE, 2'd2, 12'h000, 32'h0,         3'd0, 1'b1));
    request_queue.push_back(mk(OP_DRIVE, 2'd2, 12'h000, 32'h0,         3'd0, 1'b0));
    // Writable registers other than DIR and ICR, with upper bits set where they must drop.
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_IS,    32'h1234_5678, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_IBE,   32'hFFFF_FFFF, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_IEV,   32'h0000_005A, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_AFSEL, 32'h8000_00C3, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_LOCK,  32'hFFFF_FFFF, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_CR,    32'hDEAD_BEEF, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_PMUX,  32'h8000_0001, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_IE,    32'h0000_0001, 3'd0, 1'b0));
    // Forced edges: rising sets and raises the line, falling clears it.
    request_queue.push_back(mk(OP_EDGE,  2'd3, 12'h000, 32'h0, 3'd7, 1'b1));
    request_queue.push_back(mk(OP_EDGE,  2'd3, 12'h000, 32'h0, 3'd7, 1'b0));
    request_queue.push_back(mk(OP_EDGE,  2'd3, 12'h000, 32'h0, 3'd2, 1'b1));
    // Status registers ignore writes; clear drops raw status.
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_RIS, 32'h0,         3'd0, 1'b0));
    request_queue.push_back(mk(OP_READ,  2'd3, OFF_MIS, 32'h0,         3'd0, 1'b0));
    request_queue.push_back(mk(OP_WRITE, 2'd3, OFF_ICR, 32'h0000_00FF, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_READ,  2'd3, OFF_RIS, 32'h0,         3'd0, 1'b0));
    // Holes in the map.
    request_queue.push_back(mk(OP_WRITE, 2'd3, UNMAPPED_OFF, 32'hFFFF_FFFF, 3'd0, 1'b0));
    request_queue.push_back(mk(OP_READ,  2'd3, WINDOW_TOP,   32'h0,         3'd0, 1'b0));
    request_queue.push_back(mk(OP_READ,  2'd3, MISALIGNED,   32'h0,         3'd0, 1'b0));
    repeat (RANDOM_REQUESTS) request_queue.push_back(random_request());
    total = request_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (sent_total == total);
    // let the last acceptance reach outstanding before testing it
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d reads, %0d writes, %0d pin drives, %0d edges),",
             taken, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d results checked under shifting stalls, one drain and one long hold-off.",
             results);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/gpb_pkg.sv
hdl/gpb_port_update.sv
hdl/gpio_port_bank_registers.sv
tb/gpio_port_bank_registers_tb.sv
